/* hw/rtl/tmic_pkg.sv */
// Shared types and constants for the thermostat and motor interlock controller.
`timescale 1ns / 1ps

package tmic_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_POSITION = 2'd2
  } cmd_t;

  // Fault state codes.
  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_OVER   = 2'd2,
    FAULT_SENSOR = 2'd3
  } fault_t;

  // Motor sequencing phases.
  typedef enum logic [1:0] {
    PHASE_IDLE   = 2'd0,
    PHASE_RUN    = 2'd1,
    PHASE_SETTLE = 2'd2
  } phase_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_RUN_TICKS    = 2'd0;
  localparam logic [1:0] REG_SETTLE_TICKS = 2'd1;
  localparam logic [1:0] REG_OT_MARGIN    = 2'd2;

  // Register reset values.
  localparam logic [13:0] RUN_TICKS_RST    = 14'd8000;
  localparam logic [7:0]  SETTLE_TICKS_RST = 8'd250;
  localparam logic [8:0]  OT_MARGIN_RST    = 9'd150;

  // Temperature thresholds in tenths of a degree.
  localparam logic signed [12:0] HOT_LIMIT  = 13'sd840;
  localparam logic signed [12:0] CLAMP_HIGH = 13'sd450;
  localparam logic signed [12:0] CLAMP_LOW  = 13'sd200;
  localparam logic [8:0]         STATUS_BASE = 9'd200;
  localparam logic [8:0]         SETPOINT_RST = 9'd350;

  // Host control byte codes.
  localparam logic [7:0] CB_START    = 8'd148;
  localparam logic [7:0] CB_SET_LOW  = 8'd150;
  localparam logic [7:0] CB_SET_HIGH = 8'd250;
  localparam logic [8:0] SET_OFFSET  = 9'd150;
  localparam logic [13:0] START_GUARD = 14'd200;

  // Status codes reported while a fault is active.
  localparam logic [7:0] CODE_OVER   = 8'd252;
  localparam logic [7:0] CODE_SENSOR = 8'd253;

  // Configuration register contents.
  typedef struct packed {
    logic [13:0] run_ticks;
    logic [7:0]  settle_ticks;
    logic [8:0]  ot_margin;
  } cfg_t;

  // One input word, unpacked. The command stays a plain vector since the
  // unused code 3 can arrive and must pass through unchanged.
  typedef struct packed {
    logic [1:0]         command;
    logic signed [11:0] temperature;
    logic               sensor_ok;
    logic               door_open;
    logic               at_position;
    logic [7:0]         control_byte;
  } item_t;

  // One result word, unpacked.
  typedef struct packed {
    logic [7:0] status_code;
    logic       fault;
    logic       heater_on;
    logic       fan_on;
    logic       motor_on;
    logic       started;
  } result_t;

endpackage

/* hw/rtl/tmic_cfg.sv */
// APB configuration registers of the thermostat and motor interlock controller.
`timescale 1ns / 1ps

module tmic_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output tmic_pkg::cfg_t      cfg
);

  tmic_pkg::cfg_t cfg_r;
  tmic_pkg::cfg_t cfg_nxt;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        tmic_pkg::REG_RUN_TICKS:    cfg_nxt.run_ticks    = pwdata[13:0];
        tmic_pkg::REG_SETTLE_TICKS: cfg_nxt.settle_ticks = pwdata[7:0];
        tmic_pkg::REG_OT_MARGIN:    cfg_nxt.ot_margin    = pwdata[8:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.run_ticks    <= tmic_pkg::RUN_TICKS_RST;
      cfg_r.settle_ticks <= tmic_pkg::SETTLE_TICKS_RST;
      cfg_r.ot_margin    <= tmic_pkg::OT_MARGIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read mux.
  always_comb begin
    unique case (paddr[3:2])
      tmic_pkg::REG_RUN_TICKS:    prdata = {18'd0, cfg_r.run_ticks};
      tmic_pkg::REG_SETTLE_TICKS: prdata = {24'd0, cfg_r.settle_ticks};
      tmic_pkg::REG_OT_MARGIN:    prdata = {23'd0, cfg_r.ot_margin};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

/* hw/rtl/tmic_ctrl.sv */
// Controller state and its single-pass update for one input word.
`timescale 1ns / 1ps

module tmic_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  tmic_pkg::item_t     item,
  input  tmic_pkg::cfg_t      cfg,
  output tmic_pkg::result_t   result
);

  logic                  started_r,  started_nxt;
  logic                  tick_en_r,  tick_en_nxt;
  logic [8:0]            sp_r,       sp_nxt;
  tmic_pkg::fault_t      fault_r,    fault_nxt;
  logic [13:0]           run_cnt_r,  run_cnt_nxt;
  logic [7:0]            settle_r,   settle_nxt;
  tmic_pkg::phase_t      phase_r,    phase_nxt;
  logic                  heater_r,   heater_nxt;
  logic                  fan_r,      fan_nxt;
  logic                  motor_r,    motor_nxt;
  logic                  work_r,     work_nxt;
  logic [7:0]            status_r,   status_nxt;

  // Sample path intermediates.
  logic signed [12:0]    temp_s;
  logic [9:0]            limit;
  logic                  over;
  logic [8:0]            t_cl;
  logic                  cb_set;
  logic                  start_ok;
  logic [8:0]            sp_new;
  logic                  hot;
  logic                  door_pos;
  tmic_pkg::fault_t      fault_s;
  logic                  motor_s;

  // Tick path intermediates.
  logic [13:0]           rc_t;
  logic [7:0]            sc_t;
  tmic_pkg::phase_t      ph_t;
  logic                  motor_t;
  logic                  tick_en_t;

  assign result.status_code = status_r;
  assign result.fault       = work_r;
  assign result.heater_on   = heater_r;
  assign result.fan_on      = fan_r;
  assign result.motor_on    = motor_r;
  assign result.started     = started_r;

  // Sample: fault tracking, clamping, control byte and drive decisions.
  always_comb begin
    temp_s   = 13'(item.temperature);
    limit    = {1'b0, sp_r} + {1'b0, cfg.ot_margin};
    over     = temp_s > $signed({3'b000, limit});
    door_pos = item.door_open && item.at_position;

    if (temp_s > tmic_pkg::CLAMP_HIGH) begin
      t_cl = tmic_pkg::CLAMP_HIGH[8:0];
    end else if (temp_s < tmic_pkg::CLAMP_LOW) begin
      t_cl = tmic_pkg::CLAMP_LOW[8:0];
    end else begin
      t_cl = temp_s[8:0];
    end

    // A sensor fault sticks; over-temperature overrides it and clears itself.
    fault_s = fault_r;
    if (!item.sensor_ok) begin
      fault_s = tmic_pkg::FAULT_SENSOR;
    end
    if (over) begin
      fault_s = tmic_pkg::FAULT_OVER;
    end else if (fault_s == tmic_pkg::FAULT_OVER) begin
      fault_s = tmic_pkg::FAULT_NONE;
    end

    cb_set   = (item.control_byte >= tmic_pkg::CB_SET_LOW) &&
               (item.control_byte <= tmic_pkg::CB_SET_HIGH);
    start_ok = !cb_set && (item.control_byte == tmic_pkg::CB_START) &&
               (run_cnt_r <= tmic_pkg::START_GUARD);
    sp_new   = cb_set ? ({1'b0, item.control_byte} + tmic_pkg::SET_OFFSET) : sp_r;
    hot      = t_cl >= sp_new;

    // Position home with an expired run stops the motor; start turns it on,
    // and an open door with the motor home always wins.
    motor_s = motor_r && !door_pos && !(item.at_position && run_cnt_r == 14'd0);
    motor_s = (motor_s || start_ok) && !door_pos;
  end

  // Tick: run countdown, settle count and end of the motor cycle.
  always_comb begin
    rc_t      = run_cnt_r;
    sc_t      = settle_r;
    ph_t      = phase_r;
    motor_t   = motor_r;
    tick_en_t = tick_en_r;
    if (phase_r == tmic_pkg::PHASE_RUN && run_cnt_r != 14'd0) begin
      rc_t = run_cnt_r - 14'd1;
    end
    if (phase_r == tmic_pkg::PHASE_SETTLE) begin
      sc_t = settle_r + 8'd1;
    end
    if (rc_t == 14'd0) begin
      ph_t = tmic_pkg::PHASE_SETTLE;
    end
    if (sc_t == cfg.settle_ticks) begin
      ph_t      = tmic_pkg::PHASE_IDLE;
      sc_t      = 8'd0;
      motor_t   = 1'b0;
      tick_en_t = 1'b0;
    end
    if (item.at_position && rc_t == 14'd0) begin
      motor_t = 1'b0;
    end
  end

  // Next-state selection by item kind.
  always_comb begin
    started_nxt = started_r;
    tick_en_nxt = tick_en_r;
    sp_nxt      = sp_r;
    fault_nxt   = fault_r;
    run_cnt_nxt = run_cnt_r;
    settle_nxt  = settle_r;
    phase_nxt   = phase_r;
    heater_nxt  = heater_r;
    fan_nxt     = fan_r;
    motor_nxt   = motor_r;
    work_nxt    = work_r;
    status_nxt  = status_r;
    unique case (item.command)
      tmic_pkg::CMD_SAMPLE: begin
        if (!started_r) begin
          // Start-up wait: only a cool enough reading arms the controller.
          if (temp_s < tmic_pkg::HOT_LIMIT) begin
            started_nxt = 1'b1;
            tick_en_nxt = 1'b1;
          end
        end else begin
          fault_nxt = fault_s;
          if (fault_s == tmic_pkg::FAULT_NONE) begin
            work_nxt   = 1'b0;
            status_nxt = 8'(t_cl - tmic_pkg::STATUS_BASE);
          end else begin
            work_nxt   = 1'b1;
            status_nxt = (fault_s == tmic_pkg::FAULT_OVER) ? tmic_pkg::CODE_OVER :
                                                             tmic_pkg::CODE_SENSOR;
          end
          sp_nxt = sp_new;
          if (start_ok) begin
            phase_nxt   = tmic_pkg::PHASE_RUN;
            tick_en_nxt = 1'b1;
            run_cnt_nxt = cfg.run_ticks;
          end
          heater_nxt = !hot;
          fan_nxt    = !hot && !item.door_open;
          motor_nxt  = motor_s;
        end
      end
      tmic_pkg::CMD_TICK: begin
        if (started_r && tick_en_r) begin
          run_cnt_nxt = rc_t;
          settle_nxt  = sc_t;
          phase_nxt   = ph_t;
          motor_nxt   = motor_t;
          tick_en_nxt = tick_en_t;
        end
      end
      tmic_pkg::CMD_POSITION: begin
        if (started_r && run_cnt_r == 14'd0) begin
          motor_nxt = 1'b0;
        end
      end
      default: begin
        started_nxt = started_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      tick_en_r <= 1'b0;
      sp_r      <= tmic_pkg::SETPOINT_RST;
      fault_r   <= tmic_pkg::FAULT_NONE;
      run_cnt_r <= 14'd0;
      settle_r  <= 8'd0;
      phase_r   <= tmic_pkg::PHASE_IDLE;
      heater_r  <= 1'b0;
      fan_r     <= 1'b0;
      motor_r   <= 1'b0;
      work_r    <= 1'b0;
      status_r  <= 8'd0;
    end else if (en) begin
      started_r <= started_nxt;
      tick_en_r <= tick_en_nxt;
      sp_r      <= sp_nxt;
      fault_r   <= fault_nxt;
      run_cnt_r <= run_cnt_nxt;
      settle_r  <= settle_nxt;
      phase_r   <= phase_nxt;
      heater_r  <= heater_nxt;
      fan_r     <= fan_nxt;
      motor_r   <= motor_nxt;
      work_r    <= work_nxt;
      status_r  <= status_nxt;
    end
  end

endmodule

/* hw/rtl/thermostat_motor_interlock_controller_unit.sv */
// Top level of the thermostat and motor interlock controller.
//
//   Port group  Direction  Carries
//   in_*        slave      one item: kind in tuser, sample fields in tdata
//   out_*       master     one result word per item: status byte and drives
//   APB         slave      run ticks, settle ticks, over-temperature margin
//
// An accepted word is held in the input register, then the controller state and
// the result valid are updated together; one word per cycle while the output is
// not stalled. Reset (synchronous, active low) returns all state and registers
// but the input data register to defaults.
// A stalled output holds its word; the input register still takes one more.
`timescale 1ns / 1ps

module thermostat_motor_interlock_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // [11:0] temperature, [12] sensor_ok, [13] door_open, [14] at_position,
  // [22:15] control_byte, [23] zero
  input  logic [23:0] in_tdata,
  // [1:0] command
  input  logic [1:0]  in_tuser,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] status_code, [8] fault, [9] heater_on, [10] fan_on, [11] motor_on,
  // [12] started, [15:13] zero
  output logic [15:0] out_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                in_valid_r;
  tmic_pkg::item_t     item_r;
  logic                out_valid_r;
  logic                advance;
  tmic_pkg::cfg_t      cfg;
  tmic_pkg::result_t   result;

  // An item moves on when the result slot is empty or being emptied.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.command      <= in_tuser;
      item_r.temperature  <= in_tdata[11:0];
      item_r.sensor_ok    <= in_tdata[12];
      item_r.door_open    <= in_tdata[13];
      item_r.at_position  <= in_tdata[14];
      item_r.control_byte <= in_tdata[22:15];
    end
  end

  // Result valid; the payload is the controller state after the last item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, result.started, result.motor_on, result.fan_on,
                       result.heater_on, result.fault, result.status_code};

  tmic_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmic_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

endmodule

/* tb/sv/thermostat_motor_interlock_controller_unit_test.sv */
// Self-checking testbench for the thermostat and motor interlock controller.
`timescale 1ns / 1ps

module thermostat_motor_interlock_controller_unit_test;
  import tmic_pkg::*;

  // Command value that the controller must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Controller thresholds and codes, in tenths of a degree where they are temperatures.
  localparam int START_BELOW = 840;
  localparam int READ_MIN = 200;
  localparam int READ_MAX = 450;
  localparam int STATUS_OFFSET = 200;
  localparam logic [7:0] MOTOR_START_CODE = 8'd148;
  localparam logic [7:0] SETPOINT_MIN_CODE = 8'd150;
  localparam logic [7:0] SETPOINT_MAX_CODE = 8'd250;
  localparam int SETPOINT_BIAS = 150;
  localparam int RESTART_LIMIT = 200;
  localparam logic [7:0] STATUS_OVERHEAT = 8'd252;
  localparam logic [7:0] STATUS_SENSOR_FAIL = 8'd253;

  // Register settings for the random phases; a negative entry means drawn at random.
  localparam int PHASES = 7;
  localparam int RUN_SET [PHASES] = '{5, 1, 16383, 250, 20, 3, -1};
  localparam int SETTLE_SET [PHASES] = '{3, 1, 255, 10, 255, 2, -1};
  localparam int MARGIN_SET [PHASES] = '{150, 0, 500, 100, 300, 50, -1};
  localparam int PHASE_WORDS [PHASES] = '{140, 140, 60, 140, 140, 140, 200};

  // One row of the directed table: the word, and a typed-in result where one is given.
  typedef struct packed {
    item_t   stim;
    logic    fixed;
    result_t want;
  } script_row_t;

  localparam result_t ALL_OFF = '{8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam int SCRIPT_LEN = 25;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // Before start-up: ticks, position events, the unused command and hot readings do nothing.
    '{'{CMD_TICK, 12'sd0, 1'b1, 1'b0, 1'b1, 8'd0}, 1'b1, ALL_OFF},
    '{'{CMD_POSITION, 12'sd0, 1'b1, 1'b0, 1'b1, 8'd0}, 1'b1, ALL_OFF},
    '{'{CMD_UNUSED, 12'sd0, 1'b1, 1'b0, 1'b0, 8'd0}, 1'b1, ALL_OFF},
    '{'{CMD_SAMPLE, 12'sd1250, 1'b1, 1'b0, 1'b0, 8'd148}, 1'b1, ALL_OFF},
    '{'{CMD_SAMPLE, 12'sd840, 1'b1, 1'b0, 1'b0, 8'd0}, 1'b1, ALL_OFF},
    // A cool reading completes start-up and nothing else.
    '{'{CMD_SAMPLE, 12'sd839, 1'b1, 1'b0, 1'b0, 8'd148}, 1'b1,
      '{8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    // Coldest reading clamps to the low end; heater and fan come on.
    '{'{CMD_SAMPLE, -12'sd550, 1'b1, 1'b0, 1'b0, 8'd0}, 1'b1,
      '{8'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}},
    // Hottest reading raises the over-temperature fault.
    '{'{CMD_SAMPLE, 12'sd1250, 1'b1, 1'b0, 1'b0, 8'd255}, 1'b1,
      '{8'd252, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_SAMPLE, 12'sd350, 1'b1, 1'b0, 1'b0, 8'd0}, 1'b0, ALL_OFF},
    // Sensor failure reports its own code and stays set.
    '{'{CMD_SAMPLE, 12'sd300, 1'b0, 1'b0, 1'b0, 8'd0}, 1'b1,
      '{8'd253, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{'{CMD_SAMPLE, 12'sd300, 1'b1, 1'b0, 1'b0, 8'd0}, 1'b0, ALL_OFF},
    '{'{CMD_SAMPLE, 12'sd501, 1'b1, 1'b0, 1'b0, 8'd0}, 1'b0, ALL_OFF},
    '{'{CMD_SAMPLE, 12'sd500, 1'b1, 1'b0, 1'b0, 8'd250}, 1'b0, ALL_OFF},
    '{'{CMD_SAMPLE, 12'sd399, 1'b1, 1'b0, 1'b0, 8'd150}, 1'b0, ALL_OFF},
    // Motor start, then a start that is refused while the run is long.
    '{'{CMD_SAMPLE, 12'sd250, 1'b1, 1'b0, 1'b0, 8'd148}, 1'b0, ALL_OFF},
    '{'{CMD_SAMPLE, 12'sd250, 1'b1, 1'b0, 1'b0, 8'd148}, 1'b0, ALL_OFF},
    '{'{CMD_SAMPLE, 12'sd250, 1'b1, 1'b1, 1'b0, 8'd149}, 1'b0, ALL_OFF},
    '{'{CMD_TICK, 12'sd0, 1'b1, 1'b0, 1'b0, 8'd0}, 1'b0, ALL_OFF},
    '{'{CMD_POSITION, 12'sd0, 1'b1, 1'b0, 1'b1, 8'd0}, 1'b0, ALL_OFF},
    // Open door at the home position stops the motor.
    '{'{CMD_SAMPLE, 12'sd250, 1'b1, 1'b1, 1'b1, 8'd251}, 1'b0, ALL_OFF},
    '{'{CMD_SAMPLE, -12'sd1, 1'b1, 1'b0, 1'b0, 8'd0}, 1'b0, ALL_OFF},
    '{'{CMD_SAMPLE, 12'sd1024, 1'b1, 1'b0, 1'b0, 8'd127}, 1'b0, ALL_OFF},
    '{'{CMD_TICK, 12'sd0, 1'b1, 1'b0, 1'b1, 8'd0}, 1'b0, ALL_OFF},
    '{'{CMD_UNUSED, 12'sd1250, 1'b0, 1'b1, 1'b1, 8'd148}, 1'b0, ALL_OFF},
    '{'{CMD_SAMPLE, 12'sd449, 1'b1, 1'b0, 1'b0, 8'd170}, 1'b0, ALL_OFF}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  thermostat_motor_interlock_controller_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Predicted controller state and register contents.
  logic        st_started;
  int          st_setpoint;
  fault_t      st_fault;
  logic [13:0] st_run;
  logic [7:0]  st_settle;
  phase_t      st_phase;
  logic        st_tick_en;
  logic        drv_heater;
  logic        drv_fan;
  logic        drv_motor;
  logic        drv_work;
  logic [7:0]  st_status;
  logic [13:0] run_ticks_reg;
  logic [7:0]  settle_ticks_reg;
  logic [8:0]  margin_reg;

  // Results still owed by the block, oldest first.
  result_t awaited_results [$];

  int  failures;
  int  words_sent;
  int  results_checked;
  int  samples_sent;
  int  ticks_sent;
  int  motor_starts;
  int  settle_done;
  int  overheat_entries;
  int  sensor_failures;
  bit  no_gaps;
  int  hold_request;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The motor stops at the home position only once its run has counted out.
  function automatic void home_reached();
    if (st_run == 14'd0) drv_motor = 1'b0;
  endfunction

  function automatic void controller_reset();
    st_started = 1'b0;
    st_setpoint = 350;
    st_fault = FAULT_NONE;
    st_run = '0;
    st_settle = '0;
    st_phase = PHASE_IDLE;
    st_tick_en = 1'b0;
    drv_heater = 1'b0;
    drv_fan = 1'b0;
    drv_motor = 1'b0;
    drv_work = 1'b0;
    st_status = '0;
    run_ticks_reg = 14'd8000;
    settle_ticks_reg = 8'd250;
    margin_reg = 9'd150;
  endfunction

  // Applies one word to the predicted state and returns the outputs after it.
  function automatic result_t predict_controller(item_t it);
    result_t r;
    int      t;
    logic    door;
    logic    pos;
    t = $signed(it.temperature);
    door = it.door_open;
    pos = it.at_position;
    case (it.command)
      CMD_SAMPLE: begin
        if (!st_started) begin
          if (t < START_BELOW) begin
            st_started = 1'b1;
            st_tick_en = 1'b1;
          end
        end else begin
          // Interlocks first.
          if (door) begin
            drv_fan = 1'b0;
            if (pos) drv_motor = 1'b0;
          end
          if (pos) home_reached();

          // Sensor failure is sticky; over-temperature overrides it and clears itself.
          if (!it.sensor_ok) begin
            st_fault = FAULT_SENSOR;
            sensor_failures++;
          end
          if (t > st_setpoint + int'(margin_reg)) begin
            if (st_fault != FAULT_OVER) overheat_entries++;
            st_fault = FAULT_OVER;
          end else if (st_fault == FAULT_OVER) begin
            st_fault = FAULT_NONE;
          end

          if (t > READ_MAX) t = READ_MAX;
          else if (t < READ_MIN) t = READ_MIN;

          if (st_fault == FAULT_NONE) begin
            drv_work = 1'b0;
            st_status = 8'(t - STATUS_OFFSET);
          end else begin
            drv_work = 1'b1;
            st_status = (st_fault == FAULT_OVER) ? STATUS_OVERHEAT : STATUS_SENSOR_FAIL;
          end

          // Host control byte: a new setpoint or a motor start.
          if (it.control_byte >= SETPOINT_MIN_CODE && it.control_byte <= SETPOINT_MAX_CODE) begin
            st_setpoint = int'(it.control_byte) + SETPOINT_BIAS;
          end else if (it.control_byte == MOTOR_START_CODE && int'(st_run) <= RESTART_LIMIT) begin
            drv_motor = 1'b1;
            st_phase = PHASE_RUN;
            st_tick_en = 1'b1;
            st_run = run_ticks_reg;
            motor_starts++;
          end

          // Bang-bang heater and fan control.
          if (t >= st_setpoint) begin
            drv_heater = 1'b0;
            drv_fan = 1'b0;
            if (door && pos) drv_motor = 1'b0;
          end else begin
            if (door) begin
              drv_fan = 1'b0;
              if (pos) drv_motor = 1'b0;
            end else begin
              drv_fan = 1'b1;
            end
            drv_heater = 1'b1;
          end
        end
      end
      CMD_TICK: begin
        if (st_started && st_tick_en) begin
          if (st_phase == PHASE_RUN && st_run != 14'd0) st_run = st_run - 14'd1;
          if (st_phase == PHASE_SETTLE) st_settle = st_settle + 8'd1;
          if (st_run == 14'd0) st_phase = PHASE_SETTLE;
          if (st_settle == settle_ticks_reg) begin
            st_phase = PHASE_IDLE;
            st_settle = '0;
            drv_motor = 1'b0;
            st_tick_en = 1'b0;
            settle_done++;
          end
          if (pos) home_reached();
        end
      end
      CMD_POSITION: begin
        if (st_started) home_reached();
      end
      default: begin
      end
    endcase
    r.status_code = st_status;
    r.fault = drv_work;
    r.heater_on = drv_heater;
    r.fan_on = drv_fan;
    r.motor_on = drv_motor;
    r.started = st_started;
    return r;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    r;
    int    t;
    r = $urandom_range(0, 99);
    if (r < 45) it.command = CMD_SAMPLE;
    else if (r < 88) it.command = CMD_TICK;
    else if (r < 96) it.command = CMD_POSITION;
    else it.command = CMD_UNUSED;

    // Readings cluster around the setpoint, the fault limit and the clamp range.
    r = $urandom_range(0, 99);
    if (r < 40) t = $urandom_range(150, 650);
    else if (r < 55) t = st_setpoint + int'($urandom_range(0, 6)) - 3;
    else if (r < 70) t = st_setpoint + int'(margin_reg) + int'($urandom_range(0, 4)) - 2;
    else if (r < 85) t = int'($urandom_range(0, 1800)) - 550;
    else t = $urandom_range(180, 470);
    if (t > 1250) t = 1250;
    it.temperature = t[11:0];

    it.sensor_ok = ($urandom_range(0, 99) < 92);
    it.door_open = ($urandom_range(0, 3) == 0);
    it.at_position = ($urandom_range(0, 9) < 3);

    r = $urandom_range(0, 99);
    if (r < 12) it.control_byte = MOTOR_START_CODE;
    else if (r < 30) it.control_byte = 8'($urandom_range(150, 250));
    else if (r < 35) it.control_byte = $urandom_range(0, 1) ? 8'd149 : 8'd251;
    else it.control_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      failures++;
      if (failures <= 40)
        $display("t=%0t %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
    end
  endfunction

  // Offers one word until the block accepts it.
  task automatic offer_word(input item_t it);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, it.control_byte, it.at_position, it.door_open, it.sensor_ok,
                 it.temperature};
    in_tuser <= it.command;
    do @(posedge clk); while (!in_tready);
  endtask

  // Sends a word and records what it should produce.
  task automatic send_and_predict(input item_t it, input logic fixed, input result_t want);
    result_t predicted;
    offer_word(it);
    predicted = predict_controller(it);
    awaited_results.push_back(fixed ? want : predicted);
    words_sent++;
    if (it.command == CMD_SAMPLE) samples_sent++;
    if (it.command == CMD_TICK) ticks_sent++;
  endtask

  // Lets the block go idle: every result in, then a wait for the pipeline to empty.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes a register over the configuration port and reads it back.
  task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] rd;
    case (idx)
      REG_RUN_TICKS: mask = 32'h3FFF;
      REG_SETTLE_TICKS: mask = 32'hFF;
      default: mask = 32'h1FF;
    endcase
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd != (val & mask)) begin
      failures++;
      $display("t=%0t register %0d readback mismatch: expected %0d, actual %0d",
               $time, idx, val & mask, rd);
    end
    case (idx)
      REG_RUN_TICKS: run_ticks_reg = val[13:0];
      REG_SETTLE_TICKS: settle_ticks_reg = val[7:0];
      default: margin_reg = val[8:0];
    endcase
  endtask

  // Result side: random stalls, plus long hold-offs asked for by the sender.
  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status_code = out_tdata[7:0];
      got.fault = out_tdata[8];
      got.heater_on = out_tdata[9];
      got.fan_on = out_tdata[10];
      got.motor_on = out_tdata[11];
      got.started = out_tdata[12];
      if (awaited_results.size() == 0) begin
        failures++;
        $display("t=%0t unexpected result word: expected none, actual %h", $time, out_tdata);
      end else begin
        want = awaited_results.pop_front();
        check_field("status_code", want.status_code, got.status_code);
        check_field("fault", want.fault, got.fault);
        check_field("heater_on", want.heater_on, got.heater_on);
        check_field("fan_on", want.fan_on, got.fan_on);
        check_field("motor_on", want.motor_on, got.motor_on);
        check_field("started", want.started, got.started);
        results_checked++;
      end
    end
  end

  // Stimulus: reset, the directed table, then random phases under several settings.
  initial begin
    int run_val;
    int settle_val;
    int margin_val;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    failures = 0;
    words_sent = 0;
    results_checked = 0;
    samples_sent = 0;
    ticks_sent = 0;
    motor_starts = 0;
    settle_done = 0;
    overheat_entries = 0;
    sensor_failures = 0;
    no_gaps = 1'b0;
    hold_request = 0;
    controller_reset();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++)
      send_and_predict(SCRIPT[i].stim, SCRIPT[i].fixed, SCRIPT[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      run_val = (RUN_SET[ph] < 0) ? $urandom_range(1, 40) : RUN_SET[ph];
      settle_val = (SETTLE_SET[ph] < 0) ? $urandom_range(1, 20) : SETTLE_SET[ph];
      margin_val = (MARGIN_SET[ph] < 0) ? $urandom_range(0, 500) : MARGIN_SET[ph];
      program_reg(REG_RUN_TICKS, run_val);
      program_reg(REG_SETTLE_TICKS, settle_val);
      program_reg(REG_OT_MARGIN, margin_val);
      for (int n = 0; n < PHASE_WORDS[ph]; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 4) == 0);
        // Hold the result side off while words keep coming, so the input stalls.
        if (n == 40 && (ph == 1 || $urandom_range(0, 2) == 0)) begin
          hold_request = $urandom_range(30, 60);
          no_gaps = 1'b1;
        end
        send_and_predict(random_item(), 1'b0, ALL_OFF);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (awaited_results.size() != 0) begin
      failures++;
      $display("t=%0t %0d results never arrived", $time, awaited_results.size());
    end

    $display("Run covered %0d words (%0d samples, %0d ticks) over %0d register settings, %0d results checked.",
             words_sent, samples_sent, ticks_sent, PHASES + 1, results_checked);
    $display("Motor starts %0d, settle completions %0d, over-temperature entries %0d, sensor failures %0d.",
             motor_starts, settle_done, overheat_entries, sensor_failures);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
